/* rtl/core/sci_pkg.sv */
// ----------------------------------------------------------------------------
// sci_pkg
// Shared types and constants for the sorted calibration table interpolator.
// ----------------------------------------------------------------------------
package sci_pkg;

   localparam int TABLE_DEPTH_DEF = 512;
   localparam int FREQ_W          = 26;
   localparam int CODE_W          = 12;
   localparam int CNT_OUT_W       = 10;
   localparam int STATUS_W        = 2;
   localparam int CODE_MAX        = 4095;

   // interpolation arithmetic widths
   localparam int NUM_W  = FREQ_W + 1;          // signed freq difference
   localparam int DC_W   = CODE_W + 1;          // signed code difference
   localparam int PROD_W = NUM_W + DC_W;        // product, also divider dividend
   localparam int DEN_W  = FREQ_W;              // segment width
   localparam int SUM_W  = PROD_W + 2;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd2;

   typedef struct packed {
      logic              cmd;
      logic [FREQ_W-1:0] freq_hz;
      logic [CODE_W-1:0] voltage_code;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0]    drive_code;
      logic [STATUS_W-1:0]  status;
      logic                 saturated;
      logic [CNT_OUT_W-1:0] point_count;
   } rsp_type;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [CODE_W-1:0] code;
   } entry_type;

endpackage

/* rtl/core/sci_div.sv */
// ----------------------------------------------------------------------------
// sci_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sci_div #(
   parameter int NUM_W = sci_pkg::PROD_W,
   parameter int DEN_W = sci_pkg::DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] dvs_ff, dvs_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/sorted_cal_table_interpolator.sv */
// ----------------------------------------------------------------------------
// sorted_cal_table_interpolator
// Sorted (frequency, DAC code) calibration table with linear interpolation.
// ----------------------------------------------------------------------------
// Add: each larger entry is read, compared and shifted up one place, working
//   down from the end of the table, then the new point is written in its place.
// Query: segment scan, multiply, 40-step serial divide, clamp; a zero-width
//   segment skips the divide. One request at a time.
// Full table on add, or under two points on query: status reply only.
// Result strobes for one cycle; the receiver cannot stall.
// Reset clears the point count; table memory contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_cal_table_interpolator #(
   parameter int TABLE_DEPTH = sci_pkg::TABLE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sci_pkg::req_type req_data,
   output logic             rsp_valid,
   output sci_pkg::rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_INS_RD  = 9'b000000010,
      S_INS_CMP = 9'b000000100,
      S_Q_A     = 9'b000001000,
      S_Q_CMP   = 9'b000010000,
      S_Q_MUL   = 9'b000100000,
      S_Q_DIV   = 9'b001000000,
      S_Q_WAIT  = 9'b010000000,
      S_Q_FIN   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // table memory
   sci_pkg::entry_type mem [TABLE_DEPTH];
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   sci_pkg::entry_type mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;
   sci_pkg::entry_type mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;          // insert position or scan index
   sci_pkg::req_type  req_ff, req_in;
   sci_pkg::entry_type prev_ff, prev_in;
   sci_pkg::entry_type seg_a_ff, seg_a_in;
   sci_pkg::entry_type seg_b_ff, seg_b_in;

   logic signed [sci_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [sci_pkg::DEN_W-1:0]         den_ff, den_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sci_pkg::CODE_W-1:0]   drive_ff, drive_in;
   logic [sci_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         sat_ff, sat_in;

   logic                       div_start;
   logic                       div_done;
   logic [sci_pkg::PROD_W-1:0] div_quo;
   logic [sci_pkg::PROD_W-1:0] prod_mag;

   logic [ADDR_W-1:0] last_idx;
   logic signed [sci_pkg::NUM_W-1:0] fdiff;
   logic signed [sci_pkg::DC_W-1:0]  cdiff;
   logic signed [sci_pkg::SUM_W-1:0] qsgn;
   logic signed [sci_pkg::SUM_W-1:0] vsum;
   logic [31:0] count_wide;

   assign last_idx = ADDR_W'(count_ff - 1'b1);
   assign fdiff = signed'({1'b0, req_ff.freq_hz}) - signed'({1'b0, seg_a_ff.freq});
   assign cdiff = signed'({1'b0, seg_b_ff.code}) - signed'({1'b0, seg_a_ff.code});
   assign prod_mag = prod_ff[sci_pkg::PROD_W-1] ? sci_pkg::PROD_W'(-prod_ff)
                                                : sci_pkg::PROD_W'(prod_ff);
   assign qsgn = prod_ff[sci_pkg::PROD_W-1]
                 ? -signed'({2'b00, div_quo}) : signed'({2'b00, div_quo});
   assign vsum = signed'(sci_pkg::SUM_W'(seg_a_ff.code)) + qsgn;

   sci_div #(
      .NUM_W (sci_pkg::PROD_W),
      .DEN_W (sci_pkg::DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_mag),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      req_in       = req_ff;
      prev_in      = prev_ff;
      seg_a_in     = seg_a_ff;
      seg_b_in     = seg_b_ff;
      prod_in      = prod_ff;
      den_in       = den_ff;
      rsp_valid_in = 1'b0;
      drive_in     = drive_ff;
      status_in    = status_ff;
      sat_in       = sat_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = '{freq: req_ff.freq_hz, code: req_ff.voltage_code};
      mem_raddr    = '0;
      div_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               drive_in = '0;
               sat_in = 1'b0;
               status_in = sci_pkg::STATUS_OK;
               if (req_data.cmd == sci_pkg::CMD_ADD) begin
                  if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                     status_in = sci_pkg::STATUS_FULL;
                     rsp_valid_in = 1'b1;
                  end else begin
                     idx_in = ADDR_W'(count_ff);
                     state_in = S_INS_RD;
                  end
               end else if (count_ff < CNT_W'(2)) begin
                  status_in = sci_pkg::STATUS_SHORT;
                  rsp_valid_in = 1'b1;
               end else begin
                  mem_raddr = '0;
                  state_in = S_Q_A;
               end
            end
         end
         S_INS_RD: begin
            if (idx_ff == '0) begin
               mem_we = 1'b1;
               count_in = count_ff + 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               mem_raddr = idx_ff - 1'b1;
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            mem_we = 1'b1;
            if (mem_rdata_ff.freq > req_ff.freq_hz) begin
               // move the larger entry up one place
               mem_wdata = mem_rdata_ff;
               idx_in = idx_ff - 1'b1;
               state_in = S_INS_RD;
            end else begin
               count_in = count_ff + 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_Q_A: begin
            prev_in = mem_rdata_ff;
            idx_in = ADDR_W'(1);
            mem_raddr = ADDR_W'(1);
            state_in = S_Q_CMP;
         end
         S_Q_CMP: begin
            // rdata is entry idx; stop at first entry above freq or at the end
            if (idx_ff == last_idx || mem_rdata_ff.freq > req_ff.freq_hz) begin
               seg_a_in = prev_ff;
               seg_b_in = mem_rdata_ff;
               state_in = S_Q_MUL;
            end else begin
               prev_in = mem_rdata_ff;
               idx_in = idx_ff + 1'b1;
               mem_raddr = idx_ff + 1'b1;
            end
         end
         S_Q_MUL: begin
            prod_in = fdiff * cdiff;
            den_in = seg_b_ff.freq - seg_a_ff.freq;
            state_in = S_Q_DIV;
         end
         S_Q_DIV: begin
            if (den_ff == '0) begin
               drive_in = seg_a_ff.code;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               div_start = 1'b1;
               state_in = S_Q_WAIT;
            end
         end
         S_Q_WAIT: begin
            if (div_done) begin
               state_in = S_Q_FIN;
            end
         end
         S_Q_FIN: begin
            if (vsum < 0) begin
               drive_in = '0;
               sat_in = 1'b1;
            end else if (vsum > sci_pkg::SUM_W'(sci_pkg::CODE_MAX)) begin
               drive_in = sci_pkg::CODE_W'(sci_pkg::CODE_MAX);
               sat_in = 1'b1;
            end else begin
               drive_in = vsum[sci_pkg::CODE_W-1:0];
            end
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff    <= idx_in;
      req_ff    <= req_in;
      prev_ff   <= prev_in;
      seg_a_ff  <= seg_a_in;
      seg_b_ff  <= seg_b_in;
      prod_ff   <= prod_in;
      den_ff    <= den_in;
      drive_ff  <= drive_in;
      status_ff <= status_in;
      sat_ff    <= sat_in;
   end

   assign count_wide = 32'(count_ff);

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = '{drive_code:  drive_ff,
                        status:      status_ff,
                        saturated:   sat_ff,
                        point_count: count_wide[sci_pkg::CNT_OUT_W-1:0]};

endmodule

/* dv/sorted_cal_table_interpolator_test.sv */
// ----------------------------------------------------------------------------
// sorted_cal_table_interpolator_test
// Drives add and query requests through the command port, predicts each
// response with a local sorted table and interpolator, and compares fields.
// ----------------------------------------------------------------------------
module sorted_cal_table_interpolator_test;

   localparam int DEPTH     = sci_pkg::TABLE_DEPTH_DEF;
   localparam int FREQ_W    = sci_pkg::FREQ_W;
   localparam int CODE_W    = sci_pkg::CODE_W;
   localparam int CNT_OUT_W = sci_pkg::CNT_OUT_W;
   localparam int CODE_MAX  = sci_pkg::CODE_MAX;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   sci_pkg::req_type req_data = '0;
   logic             rsp_valid;
   sci_pkg::rsp_type rsp_data;

   logic [FREQ_W-1:0] tbl_freq[DEPTH];
   logic [CODE_W-1:0] tbl_code[DEPTH];
   int                tbl_count = 0;
   sci_pkg::rsp_type  pending_rsp[$];
   int                fail_count = 0;

   sorted_cal_table_interpolator u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   function automatic sci_pkg::rsp_type predict_response(sci_pkg::req_type r);
      sci_pkg::rsp_type o;
      int      pos, seg;
      longint  fa, fb, ca, cb, v;
      o = '0;
      if (r.cmd == sci_pkg::CMD_ADD) begin
         if (tbl_count >= DEPTH) begin
            o.status = sci_pkg::STATUS_FULL;
         end else begin
            pos = tbl_count;
            while (pos > 0 && tbl_freq[pos-1] > r.freq_hz) begin
               tbl_freq[pos] = tbl_freq[pos-1];
               tbl_code[pos] = tbl_code[pos-1];
               pos--;
            end
            tbl_freq[pos] = r.freq_hz;
            tbl_code[pos] = r.voltage_code;
            tbl_count++;
         end
      end else if (tbl_count < 2) begin
         o.status = sci_pkg::STATUS_SHORT;
      end else begin
         seg = 0;
         for (int k = 1; k + 1 < tbl_count; k++)
            if (tbl_freq[k] <= r.freq_hz) seg = k;
         fa = tbl_freq[seg];
         fb = tbl_freq[seg+1];
         ca = tbl_code[seg];
         cb = tbl_code[seg+1];
         if (fb == fa) v = ca;
         else v = ca + ((longint'(r.freq_hz) - fa) * (cb - ca)) / (fb - fa);
         if (v < 0) begin
            v = 0;
            o.saturated = 1'b1;
         end else if (v > CODE_MAX) begin
            v = CODE_MAX;
            o.saturated = 1'b1;
         end
         o.drive_code = v[CODE_W-1:0];
      end
      o.point_count = tbl_count[CNT_OUT_W-1:0];
      return o;
   endfunction

   // one request; the sender gap is drawn per request, start stays high when it is zero
   task automatic send_request(logic cmd, logic [FREQ_W-1:0] f, logic [CODE_W-1:0] c);
      sci_pkg::req_type r;
      int               gap;
      r.cmd = cmd;
      r.freq_hz = f;
      r.voltage_code = c;
      gap = $urandom_range(0, 8);
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(predict_response(r));
   endtask

   task automatic drain_responses();
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no request pending");
            fail_count++;
         end else begin
            sci_pkg::rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_data.drive_code !== e.drive_code) begin
               $error("drive_code exp %0d got %0d", e.drive_code, rsp_data.drive_code);
               fail_count++;
            end
            if (rsp_data.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.saturated !== e.saturated) begin
               $error("saturated exp %0d got %0d", e.saturated, rsp_data.saturated);
               fail_count++;
            end
            if (rsp_data.point_count !== e.point_count) begin
               $error("point_count exp %0d got %0d", e.point_count,
                      rsp_data.point_count);
               fail_count++;
            end
         end
      end
   end

   task automatic test_short_table();
      send_request(sci_pkg::CMD_QUERY, '1, '1);
      send_request(sci_pkg::CMD_ADD, 26'd1000, 12'd100);
      send_request(sci_pkg::CMD_QUERY, '0, '0);
   endtask

   task automatic test_directed_points();
      send_request(sci_pkg::CMD_ADD, 26'd1000, 12'd300);   // equal freq: zero-width segment
      send_request(sci_pkg::CMD_QUERY, 26'd1000, 12'd0);
      send_request(sci_pkg::CMD_ADD, 26'd2000, 12'd4095);
      send_request(sci_pkg::CMD_ADD, '0, 12'd0);
      send_request(sci_pkg::CMD_ADD, '1, 12'd0);
      send_request(sci_pkg::CMD_QUERY, '0, '1);
      send_request(sci_pkg::CMD_QUERY, 26'd1500, 12'd0);
      send_request(sci_pkg::CMD_QUERY, 26'd1999, 12'd0);
      send_request(sci_pkg::CMD_QUERY, 26'd3000, 12'd0);   // falling segment
      send_request(sci_pkg::CMD_QUERY, '1, 12'd0);
      send_request(sci_pkg::CMD_ADD, 26'd1010, 12'd4095);
      send_request(sci_pkg::CMD_ADD, 26'd1020, 12'd0);
      send_request(sci_pkg::CMD_QUERY, 26'd1100, 12'd0);   // rising segment from 1020 to 2000
      send_request(sci_pkg::CMD_QUERY, 26'd1015, 12'd0);
      drain_responses();
   endtask

   // fill to capacity with a mix of random and clustered points, probing as we go
   task automatic test_random_fill();
      logic [FREQ_W-1:0] f;
      for (int n = 0; n < 370; n++) begin
         if (n == 185) drain_responses();            // sender holds off until idle
         f = ($urandom_range(0, 3) == 0) ? FREQ_W'($urandom) :
             FREQ_W'($urandom_range(0, 5000));
         send_request(($urandom_range(0, 2) == 0) ? sci_pkg::CMD_ADD : sci_pkg::CMD_QUERY,
                      f, CODE_W'($urandom));
      end
      while (tbl_count < DEPTH)
         send_request(sci_pkg::CMD_ADD, FREQ_W'($urandom_range(0, 5000)),
                      CODE_W'($urandom));
      send_request(sci_pkg::CMD_ADD, '1, '1);
      send_request(sci_pkg::CMD_ADD, '0, '0);
      for (int n = 0; n < 20; n++)
         send_request(sci_pkg::CMD_QUERY, FREQ_W'($urandom), CODE_W'($urandom));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_short_table();
      test_directed_points();
      test_random_fill();
      drain_responses();
      repeat (1100) @(negedge clock);
      if (fail_count == 0) begin
         $display("sorted_cal_table_interpolator regression: pass");
      end else begin
         $display("sorted_cal_table_interpolator regression: fail");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("sorted_cal_table_interpolator regression: fail");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/sci_pkg.sv
rtl/core/sci_div.sv
rtl/core/sorted_cal_table_interpolator.sv
dv/sorted_cal_table_interpolator_test.sv
